// ===== rtl/tfags_pkg.sv =====
// Shared types and constants for the thermal frame automatic gain stretch block.
package tfags_pkg;

  localparam int MAX_FRAME_PIXELS_DEF = 131072;

  localparam logic REG_STATIC_LOW  = 1'b0;
  localparam logic REG_STATIC_HIGH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_W_MEAN,
    ST_W_SQ,
    ST_SQRT_GO,
    ST_W_SQRT,
    ST_LOHI,
    ST_LATCH,
    ST_MAP_GO,
    ST_W_MAP,
    ST_MAP_FIN
  } state_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_SQ,
    DIV_MAP
  } div_sel_t;

  typedef struct packed {
    logic     acc_en;
    logic     pix_load;
    logic     div_start;
    div_sel_t div_sel;
    logic     m8_load;
    logic     e2_load;
    logic     sq_start;
    logic     slo_load;
    logic     shi_load;
    logic     win_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sq_busy;
  } dp_stat_t;

endpackage

// ===== rtl/tfags_ctrl.sv =====
// Sequencing state machine for the statistics close and the pixel mapping.
module tfags_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_kind,
  input  logic               in_frame_end,
  output logic               in_tready,
  input  logic               out_tready,
  output logic               out_tvalid,
  output tfags_pkg::dp_cmd_t cmd,
  input  tfags_pkg::dp_stat_t stat
);

  tfags_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfags_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = tfags_pkg::DIV_MEAN;
    in_tready   = 1'b0;
    unique case (state_r)
      tfags_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind) begin
            cmd.pix_load = 1'b1;
            state_nxt    = tfags_pkg::ST_MAP_GO;
          end else begin
            cmd.acc_en = 1'b1;
            if (in_frame_end) state_nxt = tfags_pkg::ST_CLOSE;
          end
        end
      end
      tfags_pkg::ST_CLOSE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tfags_pkg::DIV_MEAN;
        state_nxt     = tfags_pkg::ST_W_MEAN;
      end
      tfags_pkg::ST_W_MEAN: begin
        if (!stat.div_busy) begin
          cmd.m8_load   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = tfags_pkg::DIV_SQ;
          state_nxt     = tfags_pkg::ST_W_SQ;
        end
      end
      tfags_pkg::ST_W_SQ: begin
        if (!stat.div_busy) begin
          cmd.e2_load = 1'b1;
          state_nxt   = tfags_pkg::ST_SQRT_GO;
        end
      end
      tfags_pkg::ST_SQRT_GO: begin
        cmd.sq_start = 1'b1;
        state_nxt    = tfags_pkg::ST_W_SQRT;
      end
      tfags_pkg::ST_W_SQRT: begin
        if (!stat.sq_busy) state_nxt = tfags_pkg::ST_LOHI;
      end
      tfags_pkg::ST_LOHI: begin
        cmd.slo_load = 1'b1;
        cmd.shi_load = 1'b1;
        state_nxt    = tfags_pkg::ST_LATCH;
      end
      tfags_pkg::ST_LATCH: begin
        cmd.win_load = 1'b1;
        state_nxt    = tfags_pkg::ST_IDLE;
      end
      tfags_pkg::ST_MAP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tfags_pkg::DIV_MAP;
        state_nxt     = tfags_pkg::ST_W_MAP;
      end
      tfags_pkg::ST_W_MAP: begin
        if (!stat.div_busy) state_nxt = tfags_pkg::ST_MAP_FIN;
      end
      tfags_pkg::ST_MAP_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = tfags_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfags_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/tfags_dp.sv =====
// Datapath: accumulators, serial divider, serial square root, window and level logic.
module tfags_dp #(
  parameter int MAX_FRAME_PIXELS = tfags_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfags_pkg::dp_cmd_t  cmd,
  output tfags_pkg::dp_stat_t stat,
  input  logic [15:0]         in_pixel,
  input  logic [16:0]         static_low,
  input  logic [16:0]         static_high,
  output logic [7:0]          level
);

  localparam int CW   = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int SW   = 16 + CW;
  localparam int QW   = 32 + CW;
  localparam int DW   = 48 + CW;
  localparam int DVW  = (CW > 16) ? CW : 16;
  localparam int CNTW = $clog2(DW + 1);

  // Division by three as a multiply by ceil(2^19/3) and a shift by 19.
  localparam logic [17:0] RECIP3 = 18'd174763;

  logic [CW-1:0]   count_r;
  logic [SW-1:0]   sum_r;
  logic [QW-1:0]   sq_r;
  logic [15:0]     pixel_r;
  logic [23:0]     m8_r;
  logic [47:0]     e2_r;
  logic [47:0]     msq_r;
  logic [15:0]     slo_r, shi_r, wmin_r, wmax_r;
  logic [7:0]      level_r;

  logic [DW-1:0]   div_quo_r;
  logic [DVW-1:0]  div_rem_r, div_den_r;
  logic [CNTW-1:0] div_cnt_r;
  logic [DVW:0]    div_tmp, div_sub;
  logic            div_ge;
  logic [DW-1:0]   dvd;
  logic [DVW-1:0]  dvs;

  logic [47:0]     sq_v_r, sq_res_r, sq_bit_r;
  logic [48:0]     sq_trial;
  logic [23:0]     s8;

  logic [24:0]     two_s;
  logic [15:0]     lo_c;
  logic [25:0]     hi_sum;
  logic [15:0]     hi_c;
  logic [15:0]     diff;
  logic [17:0]     slo_num, shi_num;
  logic [35:0]     slo_prod, shi_prod;

  logic [32:0]     mq;
  logic [15:0]     mr;
  logic [16:0]     rem2, w17;
  logic            inc1, inc2;
  logic [33:0]     q1;
  logic [15:0]     g;
  logic [8:0]      l9;
  logic [7:0]      lvl_c;

  assign s8 = sq_res_r[23:0];

  always_comb begin
    two_s    = {s8, 1'b0};
    lo_c     = ({1'b0, m8_r} > two_s) ? 16'(({1'b0, m8_r} - two_s) >> 8) : 16'd0;
    hi_sum   = {2'b00, m8_r} + {s8, 2'b00};
    hi_c     = (|hi_sum[25:24]) ? 16'hFFFF : hi_sum[23:8];
    diff     = pixel_r - wmin_r;
    slo_num  = {1'b0, slo_r, 1'b0} + {2'b00, lo_c};
    shi_num  = {1'b0, shi_r, 1'b0} + {2'b00, hi_c};
    slo_prod = slo_num * RECIP3;
    shi_prod = shi_num * RECIP3;
  end

  always_comb begin
    dvd = '0;
    dvs = '0;
    unique case (cmd.div_sel)
      tfags_pkg::DIV_MEAN: begin
        dvd[SW+7:0] = {sum_r, 8'd0};
        dvs[CW-1:0] = count_r;
      end
      tfags_pkg::DIV_SQ: begin
        dvd         = {sq_r, 16'd0};
        dvs[CW-1:0] = count_r;
      end
      tfags_pkg::DIV_MAP: begin
        dvd[31:0] = diff * 16'hFFFF;
        dvs[15:0] = wmax_r - wmin_r;
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  always_comb begin
    div_tmp = {div_rem_r, div_quo_r[DW-1]};
    div_ge  = div_tmp >= {1'b0, div_den_r};
    div_sub = div_tmp - {1'b0, div_den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= CNTW'(DW);
      div_quo_r <= dvd;
      div_rem_r <= '0;
      div_den_r <= dvs;
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
      div_quo_r <= {div_quo_r[DW-2:0], div_ge};
      div_rem_r <= div_ge ? div_sub[DVW-1:0] : div_tmp[DVW-1:0];
    end
  end

  assign sq_trial = {1'b0, sq_res_r} + {1'b0, sq_bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bit_r <= '0;
    end else if (cmd.sq_start) begin
      sq_v_r   <= (e2_r > msq_r) ? e2_r - msq_r : 48'd0;
      sq_res_r <= '0;
      sq_bit_r <= {2'b01, 46'd0};
    end else if (sq_bit_r != '0) begin
      if ({1'b0, sq_v_r} >= sq_trial) begin
        sq_v_r   <= sq_v_r - sq_trial[47:0];
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  assign stat.div_busy = div_cnt_r != '0;
  assign stat.sq_busy  = sq_bit_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      slo_r   <= 16'd0;
      shi_r   <= 16'hFFFF;
      wmin_r  <= 16'd0;
      wmax_r  <= 16'hFFFF;
    end else begin
      if (cmd.acc_en && (count_r < CW'(MAX_FRAME_PIXELS))) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SW'(in_pixel);
        sq_r    <= sq_r + QW'({16'd0, in_pixel} * {16'd0, in_pixel});
      end
      if (cmd.slo_load) slo_r <= slo_prod[34:19];
      if (cmd.shi_load) shi_r <= shi_prod[34:19];
      if (cmd.win_load) begin
        wmin_r  <= static_low[16] ? slo_r : static_low[15:0];
        wmax_r  <= static_high[16] ? shi_r : static_high[15:0];
        count_r <= '0;
        sum_r   <= '0;
        sq_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    msq_r <= m8_r * m8_r;
    if (cmd.pix_load) pixel_r <= in_pixel;
    if (cmd.m8_load)  m8_r    <= div_quo_r[23:0];
    if (cmd.e2_load)  e2_r    <= div_quo_r[47:0];
    if (cmd.out_load) level_r <= lvl_c;
  end

  always_comb begin
    mq    = div_quo_r[32:0];
    mr    = div_rem_r[15:0];
    rem2  = {mr, 1'b0};
    w17   = {1'b0, wmax_r - wmin_r};
    inc1  = (rem2 > w17) || ((rem2 == w17) && mq[0]);
    q1    = {1'b0, mq} + {33'd0, inc1};
    g     = (q1 > 34'd65535) ? 16'hFFFF : q1[15:0];
    inc2  = (g[7:0] > 8'd128) || ((g[7:0] == 8'd128) && g[8]);
    l9    = {1'b0, g[15:8]} + {8'd0, inc2};
    lvl_c = l9[8] ? 8'hFF : l9[7:0];
    priority if (pixel_r <= wmin_r) lvl_c = 8'd0;
    else if (wmax_r < wmin_r)       lvl_c = 8'd0;
    else if (wmax_r == wmin_r)      lvl_c = 8'hFF;
    else                            lvl_c = lvl_c;
  end

  assign level = level_r;

endmodule

// ===== rtl/thermal_frame_auto_gain_stretch_core.sv =====
// Top level of the thermal frame automatic gain stretch block.
// Each frame is streamed twice on the in_ channel. Pixels with tuser low form
// the statistics pass; the one with tlast high closes the frame. Pixels with
// tuser high form the mapping pass and each yields one 8-bit level on out_.
// Statistics pixels are taken one per cycle. The closing pixel starts a
// sequence of two serial divisions of 48+CW dividend bits (CW is the bit
// width of the frame pixel limit, 18 at the default) and a serial square
// root; the window smoothing and then the window latch follow, and
// in_tready is low throughout. A mapping pixel takes one serial division
// from acceptance to its level in the output register; the shared
// restoring divider serves both sequences.
// The output register holds a level until taken; a new pixel is accepted
// while it waits, and a second level waits inside the block until out_tready.
// Reset returns the window to 0..65535, clears the accumulators, sets both
// static bounds to -1 (automatic) and empties the output register.
// The APB port holds static_low at address 0 and static_high at address 4;
// a new static bound takes effect at the next frame close.
module thermal_frame_auto_gain_stretch_core #(
  parameter int MAX_FRAME_PIXELS = tfags_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // pixel[15:0]
  input  logic        in_tuser,    // kind
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // level[7:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tfags_pkg::dp_cmd_t  cmd;
  tfags_pkg::dp_stat_t stat;
  logic [16:0] static_low_r, static_high_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      static_low_r  <= 17'h1FFFF;
      static_high_r <= 17'h1FFFF;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == tfags_pkg::REG_STATIC_LOW) static_low_r  <= cfg_pwdata[16:0];
      else                                           static_high_r <= cfg_pwdata[16:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == tfags_pkg::REG_STATIC_HIGH)
                      ? {{15{static_high_r[16]}}, static_high_r}
                      : {{15{static_low_r[16]}}, static_low_r};

  tfags_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_kind      (in_tuser),
    .in_frame_end (in_tlast),
    .in_tready    (in_tready),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .cmd          (cmd),
    .stat         (stat)
  );

  tfags_dp #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_pixel    (in_tdata),
    .static_low  (static_low_r),
    .static_high (static_high_r),
    .level       (out_tdata)
  );

endmodule

// ===== rtl/tfags_chk.sv =====
// Port-level assertions for the automatic gain stretch block, with its bind.
module tfags_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic in_tlast,
  input logic out_tvalid,
  input logic out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Output transaction dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid after reset.");

  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && in_tlast |=> !in_tready)
    else $error("Input taken during frame close.");

  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("Input taken during pixel mapping.");

endmodule

bind thermal_frame_auto_gain_stretch_core tfags_chk u_chk (.*);

// ===== sim/thermal_frame_auto_gain_stretch_core_tb.sv =====
// Testbench for the thermal frame automatic gain stretch block: self-checking stream test.
module thermal_frame_auto_gain_stretch_core_tb;

  localparam int MAXPIX = tfags_pkg::MAX_FRAME_PIXELS_DEF;
  localparam int LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  thermal_frame_auto_gain_stretch_core u_dut (.*);

  always #1 clk = ~clk;

  // Predictor state.
  logic [32:0] acc_sum;
  logic [48:0] acc_sq;
  logic [17:0] acc_cnt;
  logic [15:0] sm_low, sm_high, win_lo, win_hi;
  logic signed [16:0] fix_low, fix_high;

  logic [7:0] level_q[$];
  int errors = 0, checked = 0, cycles = 0;
  int send_idle = 0, recv_stall = 0;
  bit has_closed = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (level_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected level %0d.", out_tdata);
      end else begin
        logic [7:0] want;
        want = level_q.pop_front();
        checked++;
        if (want !== out_tdata) begin
          errors++;
          if (errors <= 10) $display("Level mismatch: expected %0d, got %0d.", want, out_tdata);
        end
      end
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic close_window();
    logic [63:0] n, m8, q, r, e2, msq, v16, s8, lo, hi;
    n = (acc_cnt != 0) ? acc_cnt : 1;
    m8 = ({31'd0, acc_sum} * 256) / n;
    q = acc_sq / n;
    r = acc_sq % n;
    e2 = q * 65536 + (r * 65536) / n;
    msq = m8 * m8;
    v16 = (e2 > msq) ? e2 - msq : 0;
    s8 = isqrt(v16);
    lo = (m8 > 2 * s8) ? (m8 - 2 * s8) >> 8 : 0;
    if (lo > 65535) lo = 65535;
    hi = (m8 + 4 * s8) >> 8;
    if (hi > 65535) hi = 65535;
    sm_low = 16'((2 * 64'(sm_low) + lo) / 3);
    sm_high = 16'((2 * 64'(sm_high) + hi) / 3);
    win_lo = (fix_low >= 0) ? 16'(fix_low) : sm_low;
    win_hi = (fix_high >= 0) ? 16'(fix_high) : sm_high;
    acc_sum = 0;
    acc_sq = 0;
    acc_cnt = 0;
    has_closed = 1;
  endtask

  function automatic logic [7:0] stretch_level(logic [15:0] p);
    logic [63:0] d, w, num, q, r;
    logic [15:0] g;
    logic [8:0] lq;
    if (p <= win_lo || win_hi < win_lo) return 0;
    if (win_hi == win_lo) return 255;
    d = p - win_lo;
    w = win_hi - win_lo;
    num = d * 65535;
    q = num / w;
    r = num % w;
    if (2 * r > w || (2 * r == w && q[0])) q++;
    if (q > 65535) q = 65535;
    g = q[15:0];
    lq = {1'b0, g[15:8]};
    if (g[7:0] > 128 || (g[7:0] == 128 && lq[0])) lq++;
    if (lq > 255) lq = 255;
    return lq[7:0];
  endfunction

  task automatic send_pixel(bit kind, logic [15:0] p, bit fend);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= p;
    in_tlast <= fend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind) begin
      level_q.push_back(stretch_level(p));
    end else begin
      if (acc_cnt < MAXPIX) begin
        acc_sum += p;
        acc_sq += 49'(p) * p;
        acc_cnt++;
      end
      if (fend) close_window();
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    while (!in_tready) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic signed [16:0] v);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {{15{v[16]}}, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == 3'd0) fix_low = v;
    else fix_high = v;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] rand_pix(logic [15:0] base, int spread);
    int v;
    v = int'(base) + $urandom_range(2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic run_frame(int npix, logic [15:0] base, int spread, int nmap);
    for (int i = 0; i < npix; i++)
      send_pixel(1'b0, rand_pix(base, spread), i == npix - 1);
    for (int i = 0; i < nmap; i++)
      send_pixel(1'b1, ($urandom_range(9) == 0) ? 16'($urandom) :
                 rand_pix(base, spread * 3), $urandom_range(1));
  endtask

  task automatic test_directed();
    send_pixel(1'b1, 16'd0, 1'b0);
    send_pixel(1'b1, 16'hFFFF, 1'b1);
    send_pixel(1'b1, 16'h8000, 1'b0);
    send_pixel(1'b0, 16'hFFFF, 1'b0);
    send_pixel(1'b0, 16'h0000, 1'b1);
    send_pixel(1'b1, 16'h7FFF, 1'b0);
    send_pixel(1'b1, 16'hFFFF, 1'b0);
    send_pixel(1'b0, 16'h1234, 1'b1);
    send_pixel(1'b1, 16'h1234, 1'b0);
    send_pixel(1'b1, 16'h1235, 1'b0);
    write_reg(3'd0, 17'sd1000);
    write_reg(3'd4, 17'sd1000);
    send_pixel(1'b0, 16'd500, 1'b1);
    send_pixel(1'b1, 16'd1000, 1'b0);
    send_pixel(1'b1, 16'd1001, 1'b0);
    write_reg(3'd4, 17'sd10);
    send_pixel(1'b0, 16'd500, 1'b1);
    send_pixel(1'b1, 16'd2000, 1'b0);
    write_reg(3'd0, 17'sd0);
    write_reg(3'd4, 17'sd65535);
    send_pixel(1'b0, 16'd9, 1'b1);
    for (int i = 0; i < 4; i++) send_pixel(1'b1, 16'($urandom), 1'b0);
    write_reg(3'd0, -17'sd1);
    write_reg(3'd4, -17'sd65536);
  endtask

  task automatic test_random(int frames);
    for (int f = 0; f < frames; f++) begin
      int r;
      r = $urandom_range(5);
      if (r == 0) write_reg(3'd0, ($urandom_range(3) == 0) ? -17'sd1 : 17'($urandom_range(65535)));
      if (r == 1) write_reg(3'd4, ($urandom_range(3) == 0) ? -17'sd65536 :
                            17'($urandom_range(65535)));
      run_frame($urandom_range(1, 12), 16'($urandom), $urandom_range(4) * 4000,
                $urandom_range(4, 16));
    end
  endtask

  task automatic test_pause();
    drain();
    run_frame(5, 16'd30000, 2000, 8);
  endtask

  initial begin
    acc_sum = 0; acc_sq = 0; acc_cnt = 0;
    sm_low = 0; sm_high = 16'hFFFF; win_lo = 0; win_hi = 16'hFFFF;
    fix_low = -17'sd1; fix_high = -17'sd1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    send_idle = 0;  recv_stall = 0;  test_random(10);
    send_idle = 62; recv_stall = 0;  test_random(10);
    test_pause();
    send_idle = 0;  recv_stall = 62; test_random(10);
    send_idle = 33; recv_stall = 33; test_random(10);
    send_idle = 0;  recv_stall = 0;
    write_reg(3'd0, -17'sd1);
    write_reg(3'd4, -17'sd1);
    drain();
    $display("Ran directed window cases and %0d checked levels over random frames,", checked);
    $display("static bounds and idle and stall phases on both sides.");
    if (errors == 0 && level_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("Errors: %0d, levels still expected: %0d.", errors, level_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/tfags_pkg.sv
rtl/tfags_ctrl.sv
rtl/tfags_dp.sv
rtl/thermal_frame_auto_gain_stretch_core.sv
rtl/tfags_chk.sv
sim/thermal_frame_auto_gain_stretch_core_tb.sv
